>>> rtl/wmf3_pkg.sv
// wmf3_pkg: shared constants, types and arithmetic helpers of the weighted 3x3 max filter.
// Depends on nothing; used by rtl/weighted_max_filter_3x3_rgb.sv.
package wmf3_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int MIN_WIDTH = 3;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 13;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int WEIGHT_W  = 16;
	localparam int ROW_W     = 3 * WEIGHT_W;
	localparam int FRAC_BITS = 8;
	localparam int PROD_W    = CH_W + WEIGHT_W + 1;
	localparam int SHIFT_W   = PROD_W - FRAC_BITS;
	localparam int CFG_IDX_W = 2;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [ROW_W-1:0]   WEIGHT_RESET = 48'h0100_0100_0100;
	localparam logic [CH_W-1:0]    CH_MAX       = 8'd255;
	localparam logic [1:0]         ROW_LAST     = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_WEIGHT_TOP    = 2'd1,
		REG_WEIGHT_MIDDLE = 2'd2,
		REG_WEIGHT_BOTTOM = 2'd3
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [CH_W-1:0]  chan_t;

	// Weight one channel value, drop the fraction, clip to 0..255.
	function automatic chan_t weigh(input chan_t px, input logic [WEIGHT_W-1:0] wt);
		logic signed [PROD_W-1:0] prod;
		logic [SHIFT_W-1:0]       shifted;
		prod = $signed({{(PROD_W-CH_W){1'b0}}, px})
			* $signed({{(PROD_W-WEIGHT_W){wt[WEIGHT_W-1]}}, wt});
		shifted = prod[PROD_W-1:FRAC_BITS];
		if (prod <= 0)
			return '0;
		else if (shifted > SHIFT_W'(CH_MAX))
			return CH_MAX;
		else
			return shifted[CH_W-1:0];
	endfunction

	// Pick the weight of window row r, column c (left weight in top bits).
	function automatic logic [WEIGHT_W-1:0] weight_of(input logic [ROW_W-1:0] row,
		input int c);
		return row[ROW_W-1-WEIGHT_W*c -: WEIGHT_W];
	endfunction

endpackage

>>> rtl/weighted_max_filter_3x3_rgb.sv
// weighted_max_filter_3x3_rgb: top level of the weighted 3x3 max filter on RGB pixels.
// Depends on wmf3_pkg (constants, config register codes, weighting function).
//
// Pixels enter in raster order, one per clock when nobody stalls, and the block sustains
// one pixel per clock: a new pixel is taken every cycle while the output side keeps up.
// An accepted pixel reaches its result through the line memory read, window
// shift, weighting of the nine taps and the maximum tree into the output register. Both lines
// above the current pixel live in one 4096 x 48 synchronous memory, one word per column
// (line two up in the top half, line just above in the bottom half); it is read at the
// column of the pixel being taken and written back from stage 1 with the line moved
// down, so its single read and write port sets the rate. A write and a read of the same
// column in one cycle are forwarded. The memory is not cleared after reset: a frame must
// start with frame_start, and image_width may change only between frames. For each window
// wholly inside the image the block emits one pixel per channel, the maximum over the nine
// taps of pixel times signed Q8.8 weight (fraction dropped, negative products ignored),
// clipped to 255, with alpha 255; line_end marks the last pixel of each output line.
// image_width is clamped to 3..4096. Configuration writes are always ready and must be
// done while the block is empty.
module weighted_max_filter_3x3_rgb (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wmf3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wmf3_pkg::ROW_W-1:0]         cfg_data,
	// pixel input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [wmf3_pkg::CH_W-1:0]          red_in,
	input  logic [wmf3_pkg::CH_W-1:0]          green_in,
	input  logic [wmf3_pkg::CH_W-1:0]          blue_in,
	input  logic                               frame_start,
	// pixel output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [wmf3_pkg::CH_W-1:0]          red_out,
	output logic [wmf3_pkg::CH_W-1:0]          green_out,
	output logic [wmf3_pkg::CH_W-1:0]          blue_out,
	output logic [wmf3_pkg::CH_W-1:0]          alpha_out,
	output logic                               line_end
);

	// ---------------------------------------------------------------- configuration
	logic [wmf3_pkg::WIDTH_W-1:0] image_width_q;
	logic [wmf3_pkg::ROW_W-1:0]   weight_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= wmf3_pkg::WIDTH_RESET;
			for (int r = 0; r < 3; r++)
				weight_q[r] <= wmf3_pkg::WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (wmf3_pkg::cfg_reg_t'(cfg_index))
				wmf3_pkg::REG_IMAGE_WIDTH:   image_width_q <= cfg_data[wmf3_pkg::WIDTH_W-1:0];
				wmf3_pkg::REG_WEIGHT_TOP:    weight_q[0] <= cfg_data;
				wmf3_pkg::REG_WEIGHT_MIDDLE: weight_q[1] <= cfg_data;
				wmf3_pkg::REG_WEIGHT_BOTTOM: weight_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the width to the supported range.
	logic [wmf3_pkg::WIDTH_W-1:0] width_eff;
	always_comb begin
		if (image_width_q < wmf3_pkg::WIDTH_W'(wmf3_pkg::MIN_WIDTH))
			width_eff = wmf3_pkg::WIDTH_W'(wmf3_pkg::MIN_WIDTH);
		else if (image_width_q > wmf3_pkg::WIDTH_W'(wmf3_pkg::MAX_WIDTH))
			width_eff = wmf3_pkg::WIDTH_W'(wmf3_pkg::MAX_WIDTH);
		else
			width_eff = image_width_q;
	end

	// ---------------------------------------------------------------- flow control
	// The whole pipeline advances together unless a finished result is held by the sink.
	logic adv;
	logic accept;
	logic out_valid_q;

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && !in_stall;

	// ---------------------------------------------------------------- position tracking
	logic [wmf3_pkg::COL_W-1:0] column_count_q;
	logic [1:0]                 row_count_q;
	logic [wmf3_pkg::COL_W-1:0] col_cur;
	logic [1:0]                 row_cur;
	logic                       last_cur;
	logic                       emit_cur;

	// frame_start clears the counters before the pixel is placed.
	assign col_cur  = frame_start ? '0 : column_count_q;
	assign row_cur  = frame_start ? '0 : row_count_q;
	// A width lowered mid-line also ends the line here.
	assign last_cur = {1'b0, col_cur} >= (width_eff - wmf3_pkg::WIDTH_W'(1));
	assign emit_cur = (row_cur == wmf3_pkg::ROW_LAST) && (col_cur >= wmf3_pkg::COL_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (accept) begin
			if (last_cur) begin
				column_count_q <= '0;
				if (row_cur != wmf3_pkg::ROW_LAST)
					row_count_q <= row_cur + 2'd1;
				else
					row_count_q <= row_cur;
			end else begin
				column_count_q <= col_cur + wmf3_pkg::COL_W'(1);
				row_count_q    <= row_cur;
			end
		end
	end

	// ---------------------------------------------------------------- stage 1: line memory
	logic                       v1_q;
	wmf3_pkg::pixel_t           px_s1;
	logic [wmf3_pkg::COL_W-1:0] col_s1;
	logic                       last_s1;
	logic                       emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v1_q <= 1'b0;
		else if (adv)
			v1_q <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= {red_in, green_in, blue_in};
			col_s1  <= col_cur;
			last_s1 <= last_cur;
			emit_s1 <= emit_cur;
		end
	end

	logic [2*wmf3_pkg::PIX_W-1:0] line_mem [wmf3_pkg::MAX_WIDTH];
	logic [2*wmf3_pkg::PIX_W-1:0] rd_q;
	logic [2*wmf3_pkg::PIX_W-1:0] fwd_data_q;
	logic                         fwd_q;
	logic [2*wmf3_pkg::PIX_W-1:0] mem_word;
	logic [2*wmf3_pkg::PIX_W-1:0] wr_word;
	logic                         mem_we;
	wmf3_pkg::pixel_t             above2;
	wmf3_pkg::pixel_t             above1;

	// Forward the write-back when the next pixel reads the same column.
	assign mem_word = fwd_q ? fwd_data_q : rd_q;
	assign above2   = mem_word[2*wmf3_pkg::PIX_W-1:wmf3_pkg::PIX_W];
	assign above1   = mem_word[wmf3_pkg::PIX_W-1:0];
	// Move the lines down: the line just above becomes two up, the new pixel becomes above.
	assign wr_word  = {above1, px_s1};
	assign mem_we   = adv && v1_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[col_s1] <= wr_word;
		if (accept)
			rd_q <= line_mem[col_cur];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (accept) begin
			fwd_q <= mem_we && (col_s1 == col_cur);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			fwd_data_q <= wr_word;
	end

	// ---------------------------------------------------------------- stage 2: window
	wmf3_pkg::pixel_t win_q [3][3];
	logic             win_valid_q;
	logic             win_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win_q[r][c] <= '0;
			win_valid_q <= 1'b0;
			win_last_q  <= 1'b0;
		end else if (adv) begin
			win_valid_q <= v1_q && emit_s1;
			if (v1_q) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= above2;
				win_q[1][2] <= above1;
				win_q[2][2] <= px_s1;
				win_last_q  <= last_s1;
			end
		end
	end

	// ---------------------------------------------------------------- stage 3: weighting
	// Nine taps times three channels, each already clipped to 0..255 (clipping commutes
	// with the maximum).
	wmf3_pkg::chan_t tap_s3 [3][9];
	logic            v3_q;
	logic            last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (adv) begin
			v3_q <= win_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3 <= win_last_q;
			for (int ch = 0; ch < 3; ch++)
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						tap_s3[ch][3*r+c] <= wmf3_pkg::weigh(
							win_q[r][c][wmf3_pkg::PIX_W-1-wmf3_pkg::CH_W*ch -: wmf3_pkg::CH_W],
							wmf3_pkg::weight_of(weight_q[r], c));
		end
	end

	// ---------------------------------------------------------------- stage 4: max, output
	wmf3_pkg::chan_t ch_max [3];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			ch_max[ch] = '0;
			for (int t = 0; t < 9; t++)
				if (tap_s3[ch][t] > ch_max[ch])
					ch_max[ch] = tap_s3[ch][t];
		end
	end

	wmf3_pkg::chan_t red_q, green_q, blue_q;
	logic            line_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q      <= ch_max[0];
			green_q    <= ch_max[1];
			blue_q     <= ch_max[2];
			line_end_q <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign alpha_out = wmf3_pkg::CH_MAX;
	assign line_end  = line_end_q;

	// ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
	// Row count saturates at two and never reaches three.
	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		row_count_q != 2'd3)
		else $error("row count ran past saturation");

	// A frame-start pixel leaves the counters at column one of row zero.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> column_count_q == wmf3_pkg::COL_W'(1) && row_count_q == 2'd0)
		else $error("frame start did not restart the counters");

	// A window is marked for output only right after an emitting pixel left stage 1.
	a_win_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(win_valid_q) |-> $past(v1_q && emit_s1))
		else $error("window flagged without an emitting pixel");

	// A new result appears only when the weighting stage held one.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v3_q))
		else $error("result without a weighted window");
`endif

endmodule

>>> sim/tb_weighted_max_filter_3x3_rgb.sv
`timescale 1ns / 1ps
// Self-checking bench for the weighted 3x3 max filter on an RGB raster stream.
// Needs rtl/wmf3_pkg.sv (widths, register codes) and rtl/weighted_max_filter_3x3_rgb.sv.
// Predicts every filtered pixel in-bench and checks it against the output stream.
module tb_weighted_max_filter_3x3_rgb;
	import wmf3_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int RANDOM_PIXELS = 1200;
	localparam int PRINT_LIMIT   = 40;
	localparam int PRESET_COUNT  = 12;
	localparam int WIDE_PIXELS   = 300;
	localparam int TAIL_PIXELS   = 10;

	// Hand-picked pixels for the two opening frames: channel extremes and mixed codes.
	localparam pixel_t PRESET_PIX [2*PRESET_COUNT] = '{
		24'h000000, 24'hFFFFFF, 24'h0180FE, 24'hFE7F01, 24'h808080, 24'h00FF00,
		24'hFF0000, 24'h0000FF, 24'h7F7F7F, 24'h010101, 24'hFEFEFE, 24'h55AA33,
		24'h010203, 24'hFFFFFF, 24'h000000, 24'h030303, 24'h8000FF, 24'h40C020,
		24'hFF00FF, 24'h020202, 24'h000000, 24'h00FF80, 24'hFFFF00, 24'h123456
	};
	localparam logic [WEIGHT_W-1:0] EDGE_WEIGHTS [4] = '{
		16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF
	};

	typedef struct packed {
		pixel_t rgb;
		logic   sof;
	} raster_pix_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  eol;
	} peak_pix_t;

	// DUT ports, inputs at known values from time zero
	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_valid   = 1'b0;
	logic             cfg_ready;
	cfg_reg_t         cfg_index   = REG_IMAGE_WIDTH;
	logic [ROW_W-1:0] cfg_data    = '0;
	logic             in_valid    = 1'b0;
	logic             in_stall;
	chan_t            red_in      = '0;
	chan_t            green_in    = '0;
	chan_t            blue_in     = '0;
	logic             frame_start = 1'b0;
	logic             out_valid;
	logic             out_stall   = 1'b0;
	chan_t            red_out;
	chan_t            green_out;
	chan_t            blue_out;
	chan_t            alpha_out;
	logic             line_end;

	// Predictor copy of the configuration and of the filter state
	logic [WIDTH_W-1:0] model_width;
	logic [ROW_W-1:0]   model_weights [3];
	pixel_t             line_two_up [MAX_WIDTH];
	pixel_t             line_one_up [MAX_WIDTH];
	pixel_t             window_px [3][3];
	int                 col_pos;
	int                 rows_seen;

	raster_pix_t raster_q [$];       // pixels waiting for the driver
	peak_pix_t   window_peak_q [$];  // filtered pixels not yet seen at the output

	int pixels_queued  = 0;
	int pixels_taken   = 0;
	int peaks_checked  = 0;
	int error_count    = 0;
	int cycle_count    = 0;
	int narrowings     = 0;
	int phases         = 0;
	int send_mode      = 0;
	int stall_mode     = 0;
	int burst_left     = 0;
	int gap_left       = 0;
	int stall_tick     = 0;

	weighted_max_filter_3x3_rgb u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.alpha_out   (alpha_out),
		.line_end    (line_end)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Width as the filter uses it: values below 3 act as 3, above MAX_WIDTH as MAX_WIDTH.
	function automatic int clamped_width();
		int w;
		w = model_width;
		if (w < MIN_WIDTH) w = MIN_WIDTH;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	// Max over the nine taps of channel times signed Q8.8 weight, fraction dropped.
	// Non-positive products never win since the max starts at zero.
	function automatic chan_t weighted_peak(int lsb);
		int                  best;
		int                  prod;
		int                  wt;
		logic [WEIGHT_W-1:0] raw;
		best = 0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				raw  = model_weights[r][ROW_W-1-WEIGHT_W*c -: WEIGHT_W];
				wt   = $signed(raw);
				prod = int'(window_px[r][c][lsb +: CH_W]) * wt;
				if (prod > 0 && (prod >> FRAC_BITS) > best)
					best = prod >> FRAC_BITS;
			end
		end
		return (best > int'(CH_MAX)) ? CH_MAX : chan_t'(best);
	endfunction

	// Advance the predicted filter by one accepted pixel; queue its result if a
	// full window now lies inside the image.
	task automatic slide_window(raster_pix_t px);
		int        w;
		int        col;
		logic      last;
		peak_pix_t pk;
		w = clamped_width();
		if (px.sof) begin
			col_pos   = 0;
			rows_seen = 0;
		end
		col  = col_pos & (MAX_WIDTH - 1);
		// a width lowered below the current column ends the line right here
		last = (col >= w - 1);
		for (int r = 0; r < 3; r++) begin
			window_px[r][0] = window_px[r][1];
			window_px[r][1] = window_px[r][2];
		end
		window_px[0][2]  = line_two_up[col];
		window_px[1][2]  = line_one_up[col];
		window_px[2][2]  = px.rgb;
		line_two_up[col] = line_one_up[col];
		line_one_up[col] = px.rgb;
		if (rows_seen >= 2 && col >= 2) begin
			pk.red   = weighted_peak(2 * CH_W);
			pk.green = weighted_peak(CH_W);
			pk.blue  = weighted_peak(0);
			pk.eol   = last;
			window_peak_q.push_back(pk);
		end
		if (last) begin
			col_pos = 0;
			if (rows_seen < 2) rows_seen++;
		end else begin
			col_pos = col + 1;
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		if (error_count < PRINT_LIMIT)
			$display("%0t ns, filtered pixel %0d: %s is %0d, predicted %0d",
				$realtime, peaks_checked, what, got, want);
		error_count++;
	endtask

	// Present one register write and hold it until taken; the caller drops valid
	// after its last write so that valid stays high across back-to-back writes.
	task automatic write_reg(cfg_reg_t idx, logic [ROW_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:   model_width      = value[WIDTH_W-1:0];
			REG_WEIGHT_TOP:    model_weights[0] = value;
			REG_WEIGHT_MIDDLE: model_weights[1] = value;
			default:           model_weights[2] = value;
		endcase
	endtask

	// Wait until every pixel is taken and every filtered pixel is back, then let
	// the pipeline drain the pixels that produce nothing.
	task automatic wait_drained();
		while (pixels_taken != pixels_queued || window_peak_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_pixel(pixel_t rgb, logic sof);
		raster_pix_t p;
		p.rgb = rgb;
		p.sof = sof;
		raster_q.push_back(p);
		pixels_queued++;
	endtask

	function automatic chan_t pick_chan();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return CH_MAX;
			default: return chan_t'($urandom);
		endcase
	endfunction

	// Random pixels; with restarts on, a frame_start lands now and then mid-frame.
	task automatic queue_random(int count, logic first_sof, logic restarts);
		logic sof;
		for (int i = 0; i < count; i++) begin
			sof = (i == 0) ? first_sof : (restarts && $urandom_range(0, 79) == 0);
			push_pixel({pick_chan(), pick_chan(), pick_chan()}, sof);
		end
	endtask

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return WEIGHT_W'($urandom_range(32, 640));
			4:          return '0;
			5:          return WEIGHT_W'(32'd0 - $urandom_range(1, 600));
			6:          return EDGE_WEIGHTS[$urandom_range(0, 3)];
			default:    return WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] pick_row();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return {pick_weight(), pick_weight(), pick_weight()};
		endcase
	endfunction

	function automatic int pick_width();
		case ($urandom_range(0, 19))
			0, 1:    return $urandom_range(0, 2);
			2, 3, 4: return $urandom_range(13, 48);
			default: return $urandom_range(3, 12);
		endcase
	endfunction

	// Pixel driver: take the handshake, feed the predictor, then present the next
	// queued pixel in bursts, separated by idle gaps in all but the first send mode. A stalled pixel is held as is.
	always @(posedge clk) begin
		logic        taken;
		raster_pix_t seen;
		raster_pix_t nxt;
		taken = in_valid && !in_stall;
		if (arst_n) begin
			if (taken) begin
				seen.rgb = {red_in, green_in, blue_in};
				seen.sof = frame_start;
				slide_window(seen);
				pixels_taken++;
			end
			if (!in_valid || taken) begin
				if (gap_left > 0 || raster_q.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
				end else begin
					nxt = raster_q.pop_front();
					in_valid    <= 1'b1;
					red_in      <= nxt.rgb[2*CH_W +: CH_W];
					green_in    <= nxt.rgb[CH_W +: CH_W];
					blue_in     <= nxt.rgb[0 +: CH_W];
					frame_start <= nxt.sof;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// pick the next burst and the gap after it
						case (send_mode)
							0: begin
								burst_left = 1000;
								gap_left   = 0;
							end
							1: begin
								burst_left = $urandom_range(1, 16);
								gap_left   = $urandom_range(1, 4);
							end
							default: begin
								burst_left = $urandom_range(0, 3);
								gap_left   = $urandom_range(1, 20);
							end
						endcase
					end
				end
			end
		end
	end

	// Output backpressure: none, light random, periodic blocks, or heavy random.
	always @(posedge clk) begin
		stall_tick++;
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 3) == 0);
			2:       out_stall <= ((stall_tick % 23) < 7);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Output checker: every accepted pixel must match the oldest prediction.
	always @(posedge clk) begin
		peak_pix_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (window_peak_q.size() == 0) begin
				report_mismatch("unpredicted output, red_out", red_out, 0);
			end else begin
				want = window_peak_q.pop_front();
				if (red_out !== want.red)
					report_mismatch("red_out", red_out, want.red);
				if (green_out !== want.green)
					report_mismatch("green_out", green_out, want.green);
				if (blue_out !== want.blue)
					report_mismatch("blue_out", blue_out, want.blue);
				if (alpha_out !== CH_MAX)
					report_mismatch("alpha_out", alpha_out, CH_MAX);
				if (line_end !== want.eol)
					report_mismatch("line_end", line_end, want.eol);
				peaks_checked++;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d predictions open",
				cycle_count, window_peak_q.size());
			$display("weighted_max_filter_3x3_rgb verification failed");
			$finish;
		end
	end

	initial begin
		int               w_old;
		int               w_new;
		int               hi;
		int               count;
		int               random_pixels;
		logic             sof;
		logic [ROW_W-1:0] value;
		random_pixels = 0;
		// predictor state after reset: line stores read as zero
		model_width = WIDTH_RESET;
		for (int r = 0; r < 3; r++) begin
			model_weights[r] = WEIGHT_RESET;
			for (int c = 0; c < 3; c++) window_px[r][c] = '0;
		end
		for (int i = 0; i < MAX_WIDTH; i++) begin
			line_two_up[i] = '0;
			line_one_up[i] = '0;
		end
		col_pos   = 0;
		rows_seen = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening frame at the reset weights (all 1.0). Width register gets 0 under
		// junk in the unused upper bits: mask then clamp must give 3.
		write_reg(REG_IMAGE_WIDTH, 48'hFFFF_FFFF_E000);
		cfg_valid <= 1'b0;
		for (int i = 0; i < PRESET_COUNT; i++) push_pixel(PRESET_PIX[i], i == 0);
		wait_drained();

		// Second frame: width 2 clamps to 3; weights at their extremes (largest
		// positive, most negative, smallest step, minus one step, zero).
		send_mode  = 1;
		stall_mode = 1;
		write_reg(REG_IMAGE_WIDTH, 48'd2);
		write_reg(REG_WEIGHT_TOP, 48'h7FFF_8000_0001);
		write_reg(REG_WEIGHT_MIDDLE, 48'hFFFF_0100_0000);
		write_reg(REG_WEIGHT_BOTTOM, 48'h0180_00FF_8001);
		cfg_valid <= 1'b0;
		for (int i = PRESET_COUNT; i < 2 * PRESET_COUNT; i++)
			push_pixel(PRESET_PIX[i], i == PRESET_COUNT);
		wait_drained();

		// Random phases; each ends fully drained before the next reconfigures.
		while (random_pixels < RANDOM_PIXELS) begin
			send_mode  = $urandom_range(0, 2);
			stall_mode = $urandom_range(0, 3);
			w_old      = clamped_width();
			sof        = 1'b0;
			if (phases == 4) begin
				// Widest image: 8191 clamps to 4096. Run a long stretch of one line
				// with no early line end, then narrow to 3 mid-line to end the line.
				send_mode = 1;
				write_reg(REG_IMAGE_WIDTH, ROW_W'(13'h1FFF));
				cfg_valid <= 1'b0;
				queue_random(WIDE_PIXELS, 1'b1, 1'b0);
				wait_drained();
				write_reg(REG_IMAGE_WIDTH, 48'd3);
				cfg_valid <= 1'b0;
				narrowings++;
				queue_random(TAIL_PIXELS, 1'b0, 1'b0);
				random_pixels += WIDE_PIXELS + TAIL_PIXELS;
			end else begin
				if (col_pos >= 3 && w_old > 3 && $urandom_range(0, 4) == 0) begin
					// narrow the image with the line already at or past the new last column
					hi = (col_pos + 1 < w_old - 1) ? col_pos + 1 : w_old - 1;
					w_new = $urandom_range(3, hi);
					value = ROW_W'({$urandom, $urandom});
					value[WIDTH_W-1:0] = WIDTH_W'(w_new);
					write_reg(REG_IMAGE_WIDTH, value);
					narrowings++;
				end else begin
					if (phases == 0 || $urandom_range(0, 1) == 1) begin
						value = ROW_W'({$urandom, $urandom});
						value[WIDTH_W-1:0] = WIDTH_W'(pick_width());
						write_reg(REG_IMAGE_WIDTH, value);
						// a wider image must restart the frame so no stale column is read
						sof = (clamped_width() > w_old) || ($urandom_range(0, 1) == 1);
					end
					if (phases == 0 || $urandom_range(0, 1) == 1)
						write_reg(REG_WEIGHT_TOP, pick_row());
					if (phases == 0 || $urandom_range(0, 1) == 1)
						write_reg(REG_WEIGHT_MIDDLE, pick_row());
					if (phases == 0 || $urandom_range(0, 1) == 1)
						write_reg(REG_WEIGHT_BOTTOM, pick_row());
				end
				cfg_valid <= 1'b0;
				w_new = clamped_width();
				count = $urandom_range(1, 4) * w_new + $urandom_range(0, w_new - 1);
				queue_random(count, sof, 1'b1);
				random_pixels += count;
			end
			// hold off until every predicted pixel is back
			wait_drained();
			phases++;
		end

		$display("Checked %0d filtered pixels from %0d input pixels over %0d random phases,",
			peaks_checked, pixels_taken, phases);
		$display("widths clamped at both ends, %0d mid-line narrowings, %0d mismatches.",
			narrowings, error_count);
		if (error_count == 0) begin
			$display("weighted_max_filter_3x3_rgb verification clean");
		end else begin
			$display("weighted_max_filter_3x3_rgb verification failed");
		end
		$finish;
	end

endmodule
